// ===== rtl/emh_pkg.sv =====
package emh_pkg;

  // Kinds of input transaction carried on in_tuser.
  typedef enum logic [1:0] {
    ACT_RECORD     = 2'd0,
    ACT_READ_BIN   = 2'd1,
    ACT_READ_CLASS = 2'd2
  } action_t;

  // Histogram selector codes.
  localparam logic [2:0] HSEL_TOTAL_HIT     = 3'd6;
  localparam logic [2:0] HSEL_TOTAL_CLUSTER = 3'd7;

  localparam int NUM_LANES   = 8;
  localparam int NUM_CLASSES = 6;
  localparam int CNT_W       = 10;   // per-chamber count width
  localparam int IDX_W       = 16;   // wide enough for any bin index or depth
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 32;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Unpacked input transaction payload. The last member sits in the lowest
  // bits, so hits_top lines up with in_tdata[9:0].
  typedef struct packed {
    logic [2:0] counter_select;
    logic [11:0] bin_index;
    logic [2:0] histogram_select;
    cnt_t       clusters_bottom;
    cnt_t       clusters_middle;
    cnt_t       clusters_top;
    cnt_t       hits_bottom;
    cnt_t       hits_middle;
    cnt_t       hits_top;
  } item_t;

  // Pipeline control shared by all lanes.
  typedef struct packed {
    logic clr;     // clearing pass active
    logic acc;     // input transaction accepted this cycle
    logic leave;   // stage one item moves on this cycle
  } lane_ctl_t;

endpackage

// ===== rtl/emh_lane.sv =====
module emh_lane
  import emh_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int COUNT_BITS = 32,
  parameter int CLR_W      = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl,
  input  logic [CLR_W-1:0]         clr_addr,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     inc,
  output logic [COUNT_BITS-1:0]    value
);

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_r;
  logic [COUNT_BITS-1:0] fwd_val_r;
  logic                  fwd_hit_r;
  logic [AW-1:0]         p1_addr_r;
  logic                  p1_inc_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [AW-1:0]         wa;
  logic                  we;
  logic [COUNT_BITS-1:0] wd;

  // Current count with forwarding from the item just ahead.
  assign value   = fwd_hit_r ? fwd_val_r : rd_r;
  assign cnt_nxt = value + 1'b1;

  // Single write port: clearing pass or incremented count.
  always_comb begin
    wa = p1_addr_r;
    wd = cnt_nxt;
    we = ctl.leave && p1_inc_r;
    if (ctl.clr) begin
      wa = clr_addr[AW-1:0];
      wd = '0;
      we = (32'(clr_addr) < DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.acc) begin
      rd_r      <= mem[addr];
      p1_addr_r <= addr;
      fwd_val_r <= cnt_nxt;
    end
  end

  // Control flags of stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_inc_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (ctl.acc) begin
      p1_inc_r  <= inc;
      fwd_hit_r <= ctl.leave && p1_inc_r && (addr == p1_addr_r);
    end
  end

endmodule

// ===== rtl/event_multiplicity_histogrammer.sv =====
// Pipeline: an accepted read passes the stage-one registers and the output
// register before it is presented; record transactions give no result.
// Throughput: one transaction per cycle while the output is not stalled; each
// histogram lane owns one bin memory with one read and one write port, and
// read-modify-write hazards are forwarded. Reset: synchronous, active low;
// a clearing pass then zeroes all bins, during which in_tready stays low.
module event_multiplicity_histogrammer
  import emh_pkg::*;
#(
  parameter int CHAMBER_BINS = 1024,
  parameter int TOTAL_BINS   = 4096,
  parameter int COUNT_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // hits_top, hits_middle, hits_bottom, clusters_top, clusters_middle,
  // clusters_bottom, histogram_select, bin_index, counter_select, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // read_value
  output logic                  out_tuser   // out_of_range
);

  localparam int MAXB  = (CHAMBER_BINS > TOTAL_BINS) ? CHAMBER_BINS : TOTAL_BINS;
  localparam int CLR_W = $clog2(MAXB);
  localparam int CAW   = $clog2(CHAMBER_BINS);
  localparam int TAW   = $clog2(TOTAL_BINS);

  item_t                 it;
  action_t               act;
  lane_ctl_t             ctl;
  logic                  acc;
  logic                  adv;
  logic                  clr_r;
  logic [CLR_W-1:0]      clr_cnt_r;
  logic                  p1_v_r;
  logic                  p1_busy_r;
  logic                  p1_class_r;
  logic                  p1_bad_r;
  logic [2:0]            p1_sel_r;
  logic [COUNT_BITS-1:0] p1_val_r;
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_bad_r;
  logic [COUNT_BITS-1:0] class_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] class_hit;
  idx_t                  cidx [6];
  idx_t                  sum_h;
  idx_t                  sum_c;
  idx_t                  bidx;
  logic [NUM_LANES-1:0]  lane_inc;
  logic [COUNT_BITS-1:0] lane_val [NUM_LANES];
  logic [COUNT_BITS-1:0] res_val;
  logic                  rd_bad;
  logic [63:0]           res_wide;

  // Unpack the transaction.
  assign it  = item_t'(in_tdata[77:0]);
  assign act = action_t'(in_tuser);

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !clr_r && adv;
  assign acc       = in_tvalid && in_tready;
  assign ctl       = '{clr: clr_r, acc: acc, leave: adv && p1_busy_r};

  // Per-lane indices: chamber counts, totals and the read bin.
  assign cidx[0] = IDX_W'(it.hits_top);
  assign cidx[1] = IDX_W'(it.hits_middle);
  assign cidx[2] = IDX_W'(it.hits_bottom);
  assign cidx[3] = IDX_W'(it.clusters_top);
  assign cidx[4] = IDX_W'(it.clusters_middle);
  assign cidx[5] = IDX_W'(it.clusters_bottom);
  assign sum_h   = cidx[0] + cidx[1] + cidx[2];
  assign sum_c   = cidx[3] + cidx[4] + cidx[5];
  assign bidx    = IDX_W'(it.bin_index);

  // Increment enables, only for record transactions within depth.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      lane_inc[k] = (act == ACT_RECORD) && (32'(cidx[k]) < CHAMBER_BINS);
    end
    lane_inc[6] = (act == ACT_RECORD) && (32'(sum_h) < TOTAL_BINS);
    lane_inc[7] = (act == ACT_RECORD) && (32'(sum_c) < TOTAL_BINS);
  end

  // Class conditions of one event.
  always_comb begin
    class_hit[0] = (cidx[0] == '0) || (cidx[1] == '0) || (cidx[2] == '0);
    class_hit[1] = 1'b1;
    class_hit[2] = 1'b0;
    class_hit[3] = 1'b1;
    class_hit[4] = 1'b1;
    class_hit[5] = 1'b0;
    for (int k = 0; k < 3; k++) begin
      class_hit[1] = class_hit[1] && (cidx[k] == 16'd1 || cidx[k] == 16'd2);
      class_hit[2] = class_hit[2] || (cidx[k] > 16'd2);
      class_hit[3] = class_hit[3] && (cidx[k+3] == 16'd1);
      class_hit[4] = class_hit[4] && (cidx[k+3] == 16'd2);
      class_hit[5] = class_hit[5] || (cidx[k+3] > 16'd2);
    end
  end

  // Histogram lanes.
  for (genvar g = 0; g < 6; g++) begin : g_chamber
    emh_lane #(.DEPTH(CHAMBER_BINS), .COUNT_BITS(COUNT_BITS), .CLR_W(CLR_W)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .clr_addr (clr_cnt_r),
      .addr     ((act == ACT_RECORD) ? cidx[g][CAW-1:0] : bidx[CAW-1:0]),
      .inc      (lane_inc[g]),
      .value    (lane_val[g])
    );
  end

  emh_lane #(.DEPTH(TOTAL_BINS), .COUNT_BITS(COUNT_BITS), .CLR_W(CLR_W)) u_total_hit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .clr_addr (clr_cnt_r),
    .addr     ((act == ACT_RECORD) ? sum_h[TAW-1:0] : bidx[TAW-1:0]),
    .inc      (lane_inc[6]),
    .value    (lane_val[6])
  );

  emh_lane #(.DEPTH(TOTAL_BINS), .COUNT_BITS(COUNT_BITS), .CLR_W(CLR_W)) u_total_clu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .clr_addr (clr_cnt_r),
    .addr     ((act == ACT_RECORD) ? sum_c[TAW-1:0] : bidx[TAW-1:0]),
    .inc      (lane_inc[7]),
    .value    (lane_val[7])
  );

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == MAXB - 1) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Class counters update as a record transaction is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        class_r[k] <= '0;
      end
    end else if (acc && act == ACT_RECORD) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (class_hit[k]) begin
          class_r[k] <= class_r[k] + 1'b1;
        end
      end
    end
  end

  // Range check of a bin read.
  always_comb begin
    if (it.histogram_select == HSEL_TOTAL_HIT || it.histogram_select == HSEL_TOTAL_CLUSTER) begin
      rd_bad = !(32'(bidx) < TOTAL_BINS);
    end else begin
      rd_bad = !(32'(bidx) < CHAMBER_BINS);
    end
  end

  // Stage one control: busy for any transaction, valid only for reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p1_busy_r <= 1'b0;
    end else if (adv) begin
      p1_v_r    <= acc && (act == ACT_READ_BIN || act == ACT_READ_CLASS);
      p1_busy_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_class_r <= (act == ACT_READ_CLASS);
      p1_sel_r   <= it.histogram_select;
      if (act == ACT_READ_CLASS) begin
        p1_bad_r <= !(it.counter_select < 3'(NUM_CLASSES));
        p1_val_r <= (it.counter_select < 3'(NUM_CLASSES)) ? class_r[it.counter_select] : '0;
      end else begin
        p1_bad_r <= rd_bad;
        p1_val_r <= '0;
      end
    end
  end

  // Merge: pick the lane or class value for the result.
  always_comb begin
    if (p1_bad_r) begin
      res_val = '0;
    end else if (p1_class_r) begin
      res_val = p1_val_r;
    end else begin
      res_val = lane_val[p1_sel_r];
    end
    res_wide = 64'(res_val);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p1_v_r) begin
      out_data_r <= res_wide[OUT_DATA_W-1:0];
      out_bad_r  <= p1_bad_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  // No transaction is taken while bins are being cleared.
  a_no_acc_clr: assert property (@(posedge clk) disable iff (!rst_n) clr_r |-> !acc)
    else $error("input accepted during clearing pass");

  // An out-of-range result carries a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_bad_r) |-> (out_data_r == '0))
    else $error("out-of-range result with nonzero value");

  // Reset starts the clearing pass.
  a_clr_after_rst: assert property (@(posedge clk) !rst_n |=> clr_r)
    else $error("clearing pass not started after reset");

  // A read in stage one reaches the output register when the pipeline advances.
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && adv) |=> out_v_r)
    else $error("result lost between stage one and output");

endmodule
